// File: src/i2cee_pkg.sv
// ----------------------------------------------------------------------------
// i2cee_pkg
// Shared types and codes of the serial EEPROM bus master.
// ----------------------------------------------------------------------------
package i2cee_pkg;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_LOAD  = 2'd1;
    localparam logic [1:0] CMD_START = 2'd2;

    localparam logic [1:0] REG_DEVICE_ADDRESS = 2'd0;
    localparam logic [1:0] REG_HALF_TICKS     = 2'd1;
    localparam logic [1:0] REG_HOLD_TICKS     = 2'd2;

    localparam logic [6:0]  RST_DEVICE_ADDRESS = 7'd80;
    localparam logic [15:0] RST_HALF_TICKS     = 16'd5;
    localparam logic [15:0] RST_HOLD_TICKS     = 16'd10;

    localparam int CMD_QUEUE_DEPTH = 2;
    localparam int RES_QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        CLS_TICK,
        CLS_LOAD,
        CLS_START,
        CLS_NONE
    } cls_t;

    typedef enum logic [4:0] {
        P_IDLE, P_STA_A, P_STA_B, P_STA_C, P_WLO, P_WHI, P_ALO, P_AHI1, P_AHI2,
        P_AEND, P_RLO, P_RHI1, P_RHI2, P_MLO, P_MHI, P_NLO, P_NHI, P_SPA,
        P_SPB, P_SPC
    } phase_t;

    typedef enum logic [2:0] {
        S_DEV, S_AHI, S_ALO, S_DATA, S_DEVR, S_READ
    } stage_t;

    typedef struct packed {
        cls_t        cls;
        logic        sda;
        logic        rnw;
        logic [15:0] addr;
        logic [7:0]  count;
        logic [7:0]  wdata;
    } item_t;

    typedef struct packed {
        logic       scl_release;
        logic       sda_release;
        logic [7:0] rdata;
        logic       rdata_valid;
        logic       done_res;
        logic [7:0] nack_count;
        logic       busy_res;
    } result_t;

    typedef struct packed {
        logic        we;
        logic [1:0]  index;
        logic [15:0] data;
    } cfg_write_t;

endpackage

// File: src/i2cee_queue.sv
// ----------------------------------------------------------------------------
// i2cee_queue
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module i2cee_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= din;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count beyond depth");

    a_pop_advances: assert property (@(posedge clk) disable iff (!rst_n)
        do_pop && !do_push |=> count_reg == $past(count_reg) - 1'b1)
        else $error("pop beat did not drain an entry");

    a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
        do_push && !do_pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("push beat did not add an entry");

endmodule

// File: src/i2cee_front.sv
// ----------------------------------------------------------------------------
// i2cee_front
// Input side: decode the command, clamp the burst length, queue the beat.
// ----------------------------------------------------------------------------
module i2cee_front #(
    parameter int MAX_BURST = 128
) (
    input  logic                push,
    output logic                full,
    input  logic [1:0]          cmd,
    input  logic                sda_in,
    input  logic                read_not_write,
    input  logic [15:0]         mem_address,
    input  logic [7:0]          byte_count,
    input  logic [7:0]          wdata,
    input  logic                q_full,
    output logic                q_push,
    output i2cee_pkg::item_t    q_item
);
    import i2cee_pkg::*;

    cls_t       cls;
    logic [7:0] count;

    always_comb
    begin
        unique case (cmd)
            CMD_TICK:  cls = CLS_TICK;
            CMD_LOAD:  cls = CLS_LOAD;
            CMD_START: cls = CLS_START;
            default:   cls = CLS_NONE;
        endcase
    end

    always_comb
    begin
        if (byte_count == 8'd0)
        begin
            count = 8'd1;
        end
        else if (byte_count > 8'(MAX_BURST))
        begin
            count = 8'(MAX_BURST);
        end
        else
        begin
            count = byte_count;
        end
    end

    assign full   = q_full;
    assign q_push = push && !q_full;

    always_comb
    begin
        q_item.cls   = cls;
        q_item.sda   = sda_in;
        q_item.rnw   = read_not_write;
        q_item.addr  = mem_address;
        q_item.count = count;
        q_item.wdata = wdata;
    end

endmodule

// File: src/i2cee_back.sv
// ----------------------------------------------------------------------------
// i2cee_back
// Sequencer: one beat a cycle unless stalled, write buffer, result per beat.
// ----------------------------------------------------------------------------
module i2cee_back #(
    parameter int MAX_BURST = 128
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  i2cee_pkg::cfg_write_t cfg,
    input  logic                  cq_empty,
    input  i2cee_pkg::item_t      item,
    output logic                  cq_pop,
    input  logic                  rq_full,
    output logic                  rq_push,
    output i2cee_pkg::result_t    res
);
    import i2cee_pkg::*;

    localparam int AW = (MAX_BURST > 1) ? $clog2(MAX_BURST) : 1;

    logic [6:0]  dev_addr_reg;
    logic [15:0] half_reg;
    logic [15:0] hold_reg;

    phase_t      phase_reg, phase_next;
    stage_t      stage_reg, stage_next;
    logic [15:0] tick_reg, tick_next;
    logic [3:0]  bit_reg, bit_next;
    logic [7:0]  shift_reg, shift_next;
    logic [7:0]  left_reg, left_next;
    logic [15:0] addr_reg, addr_next;
    logic [7:0]  err_reg, err_next;
    logic [7:0]  lp_reg, lp_next;
    logic        is_read_reg, is_read_next;

    logic [7:0]  mem [MAX_BURST];
    logic [7:0]  buf_q_reg;
    logic        rd_ok_reg;
    logic        mem_we;
    logic        fire;

    function automatic logic is_long(phase_t p);
        case (p) inside
            P_STA_A, P_STA_B, P_AHI1, P_AHI2, P_RHI1, P_RHI2, P_SPB, P_SPC:
                return 1'b1;
            default:
                return 1'b0;
        endcase
    endfunction

    function automatic logic scl_level(phase_t p);
        case (p) inside
            P_IDLE, P_STA_A, P_STA_B, P_WHI, P_AHI1, P_AHI2, P_RHI1, P_RHI2,
            P_MHI, P_NHI, P_SPB, P_SPC:
                return 1'b1;
            default:
                return 1'b0;
        endcase
    endfunction

    function automatic logic sda_level(phase_t p, logic msb);
        case (p) inside
            P_WLO, P_WHI:
                return msb;
            P_STA_B, P_STA_C, P_MLO, P_MHI, P_SPA, P_SPB:
                return 1'b0;
            default:
                return 1'b1;
        endcase
    endfunction

    function automatic logic [15:0] phase_len(phase_t p, logic [15:0] half,
                                              logic [15:0] hold);
        logic [15:0] d;
        d = is_long(p) ? hold : half;
        return (d == 16'd0) ? 16'd1 : d;
    endfunction

    assign fire    = !cq_empty && !rq_full;
    assign cq_pop  = fire;
    assign rq_push = fire;

    always_comb
    begin
        logic [15:0] cnt_dec;
        logic [7:0]  sh;
        logic [3:0]  bi;
        logic [7:0]  bdata;

        phase_next   = phase_reg;
        stage_next   = stage_reg;
        tick_next    = tick_reg;
        bit_next     = bit_reg;
        shift_next   = shift_reg;
        left_next    = left_reg;
        addr_next    = addr_reg;
        err_next     = err_reg;
        lp_next      = lp_reg;
        is_read_next = is_read_reg;
        mem_we       = 1'b0;
        res.rdata       = 8'h00;
        res.rdata_valid = 1'b0;
        res.done_res    = 1'b0;

        cnt_dec = tick_reg - 16'd1;
        sh      = shift_reg;
        bi      = bit_reg;
        bdata   = rd_ok_reg ? buf_q_reg : 8'h00;

        if (fire)
        begin
            case (item.cls)
                CLS_TICK:
                begin
                    if (phase_reg != P_IDLE)
                    begin
                        if (phase_reg == P_AHI1 && tick_reg == 16'd1 && item.sda &&
                            err_reg != 8'hFF)
                        begin
                            err_next = err_reg + 8'd1;
                        end
                        if (phase_reg == P_RHI1 && tick_reg == 16'd1)
                        begin
                            sh = {shift_reg[6:0], item.sda};
                            bi = bit_reg + 4'd1;
                            if (bi == 4'd8)
                            begin
                                res.rdata       = sh;
                                res.rdata_valid = 1'b1;
                            end
                        end
                        shift_next = sh;
                        bit_next   = bi;
                        tick_next  = cnt_dec;
                        if (cnt_dec == 16'd0)
                        begin
                            unique case (phase_reg)
                                P_STA_A: phase_next = P_STA_B;
                                P_STA_B: phase_next = P_STA_C;
                                P_STA_C:
                                begin
                                    shift_next = {dev_addr_reg, stage_reg == S_DEVR};
                                    bit_next   = 4'd0;
                                    phase_next = P_WLO;
                                end
                                P_WLO:   phase_next = P_WHI;
                                P_WHI:
                                begin
                                    shift_next = {sh[6:0], 1'b0};
                                    bit_next   = bi + 4'd1;
                                    phase_next = (bit_next < 4'd8) ? P_WLO : P_ALO;
                                end
                                P_ALO:   phase_next = P_AHI1;
                                P_AHI1:  phase_next = P_AHI2;
                                P_AHI2:  phase_next = P_AEND;
                                P_AEND:
                                begin
                                    unique case (stage_reg)
                                        S_DEV:
                                        begin
                                            stage_next = S_AHI;
                                            shift_next = addr_reg[15:8];
                                            bit_next   = 4'd0;
                                            phase_next = P_WLO;
                                        end
                                        S_AHI:
                                        begin
                                            stage_next = S_ALO;
                                            shift_next = addr_reg[7:0];
                                            bit_next   = 4'd0;
                                            phase_next = P_WLO;
                                        end
                                        S_ALO:
                                        begin
                                            if (is_read_reg)
                                            begin
                                                stage_next = S_DEVR;
                                                phase_next = P_STA_A;
                                            end
                                            else
                                            begin
                                                stage_next = S_DATA;
                                                shift_next = bdata;
                                                bit_next   = 4'd0;
                                                lp_next    = lp_reg + 8'd1;
                                                phase_next = P_WLO;
                                            end
                                        end
                                        S_DATA:
                                        begin
                                            left_next = left_reg - 8'd1;
                                            if (left_next != 8'd0)
                                            begin
                                                shift_next = bdata;
                                                bit_next   = 4'd0;
                                                lp_next    = lp_reg + 8'd1;
                                                phase_next = P_WLO;
                                            end
                                            else
                                            begin
                                                phase_next = P_SPA;
                                            end
                                        end
                                        default:
                                        begin
                                            stage_next = S_READ;
                                            shift_next = 8'h00;
                                            bit_next   = 4'd0;
                                            phase_next = P_RLO;
                                        end
                                    endcase
                                end
                                P_RLO:   phase_next = P_RHI1;
                                P_RHI1:  phase_next = P_RHI2;
                                P_RHI2:
                                begin
                                    if (bi < 4'd8)
                                    begin
                                        phase_next = P_RLO;
                                    end
                                    else
                                    begin
                                        left_next  = left_reg - 8'd1;
                                        phase_next = (left_next != 8'd0) ? P_MLO : P_NLO;
                                    end
                                end
                                P_MLO:   phase_next = P_MHI;
                                P_MHI:
                                begin
                                    shift_next = 8'h00;
                                    bit_next   = 4'd0;
                                    phase_next = P_RLO;
                                end
                                P_NLO:   phase_next = P_NHI;
                                P_NHI:   phase_next = P_SPA;
                                P_SPA:   phase_next = P_SPB;
                                P_SPB:   phase_next = P_SPC;
                                default:
                                begin
                                    res.done_res = 1'b1;
                                    phase_next   = P_IDLE;
                                    lp_next      = 8'd0;
                                end
                            endcase
                            tick_next = (phase_next == P_IDLE) ? 16'd0 :
                                        phase_len(phase_next, half_reg, hold_reg);
                        end
                    end
                end
                CLS_LOAD:
                begin
                    if (phase_reg == P_IDLE && lp_reg < 8'(MAX_BURST))
                    begin
                        mem_we  = 1'b1;
                        lp_next = lp_reg + 8'd1;
                    end
                end
                CLS_START:
                begin
                    if (phase_reg == P_IDLE)
                    begin
                        left_next    = item.count;
                        addr_next    = item.addr;
                        is_read_next = item.rnw;
                        err_next     = 8'd0;
                        lp_next      = 8'd0;
                        stage_next   = S_DEV;
                        bit_next     = 4'd0;
                        shift_next   = 8'h00;
                        phase_next   = P_STA_A;
                        tick_next    = phase_len(P_STA_A, half_reg, hold_reg);
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (item.cls == CLS_TICK)
        begin
            res.scl_release = scl_level(phase_reg);
            res.sda_release = sda_level(phase_reg, shift_reg[7]);
            res.busy_res    = (phase_reg != P_IDLE);
        end
        else
        begin
            res.scl_release = scl_level(phase_next);
            res.sda_release = sda_level(phase_next, shift_next[7]);
            res.busy_res    = (phase_next != P_IDLE);
        end
        res.nack_count = err_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_addr_reg <= RST_DEVICE_ADDRESS;
            half_reg     <= RST_HALF_TICKS;
            hold_reg     <= RST_HOLD_TICKS;
        end
        else if (cfg.we)
        begin
            unique case (cfg.index)
                REG_DEVICE_ADDRESS: dev_addr_reg <= cfg.data[6:0];
                REG_HALF_TICKS:     half_reg     <= cfg.data;
                REG_HOLD_TICKS:     hold_reg     <= cfg.data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= P_IDLE;
            stage_reg   <= S_DEV;
            tick_reg    <= '0;
            bit_reg     <= '0;
            shift_reg   <= '0;
            left_reg    <= '0;
            addr_reg    <= '0;
            err_reg     <= '0;
            lp_reg      <= '0;
            is_read_reg <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            stage_reg   <= stage_next;
            tick_reg    <= tick_next;
            bit_reg     <= bit_next;
            shift_reg   <= shift_next;
            left_reg    <= left_next;
            addr_reg    <= addr_next;
            err_reg     <= err_next;
            lp_reg      <= lp_next;
            is_read_reg <= is_read_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[lp_reg[AW-1:0]] <= item.wdata;
        end
        buf_q_reg <= mem[lp_reg[AW-1:0]];
        rd_ok_reg <= (lp_reg < 8'(MAX_BURST));
    end

    a_rvalid_full_byte: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res.rdata_valid |=> bit_reg == 4'd8)
        else $error("read byte flagged before eighth bit");

    a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res.done_res |=> phase_reg == P_IDLE && lp_reg == 8'd0)
        else $error("stop completed without returning to idle");

    a_pointer_bound: assert property (@(posedge clk) disable iff (!rst_n)
        lp_reg <= 8'(MAX_BURST))
        else $error("buffer pointer beyond burst limit");

    a_bit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        bit_reg <= 4'd8)
        else $error("bit index beyond a byte");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(phase_reg) && $stable(tick_reg))
        else $error("sequencer advanced without a beat");

endmodule

// File: src/i2c_eeprom_access_master.sv
// ----------------------------------------------------------------------------
// i2c_eeprom_access_master
// Bus master for a two-byte-addressed serial EEPROM, one tick per beat.
//
//   channel   handshake          payload
//   input     push / full        cmd sda_in read_not_write mem_address
//                                byte_count wdata
//   result    empty / pop        scl_release sda_release rdata rdata_valid
//                                done_res nack_count busy_res
//   config    cfg_we             cfg_index cfg_data
//
// One input beat a cycle while the result side pops; each beat gives exactly
// one result beat, which is queued in turn in the command and result queues.
// The sequencer steps one queued beat a cycle, held while the result queue is
// full; input and result queues are two deep, so full rises only under stall.
// Reset needs no clearing pass; the write buffer holds undefined data until
// loaded.
// ----------------------------------------------------------------------------
module i2c_eeprom_access_master #(
    parameter int MAX_BURST = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  cmd,
    input  logic        sda_in,
    input  logic        read_not_write,
    input  logic [15:0] mem_address,
    input  logic [7:0]  byte_count,
    input  logic [7:0]  wdata,
    output logic        empty,
    input  logic        pop,
    output logic        scl_release,
    output logic        sda_release,
    output logic [7:0]  rdata,
    output logic        rdata_valid,
    output logic        done_res,
    output logic [7:0]  nack_count,
    output logic        busy_res,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import i2cee_pkg::*;

    item_t      fe_item;
    item_t      be_item;
    logic       fe_push;
    logic       cq_full;
    logic       cq_empty;
    logic       cq_pop;
    result_t    be_res;
    result_t    out_res;
    logic       rq_full;
    logic       rq_push;
    cfg_write_t cfg;

    always_comb
    begin
        cfg.we    = cfg_we;
        cfg.index = cfg_index;
        cfg.data  = cfg_data;
    end

    i2cee_front #(
        .MAX_BURST (MAX_BURST)
    ) u_front (
        .push           (push),
        .full           (full),
        .cmd            (cmd),
        .sda_in         (sda_in),
        .read_not_write (read_not_write),
        .mem_address    (mem_address),
        .byte_count     (byte_count),
        .wdata          (wdata),
        .q_full         (cq_full),
        .q_push         (fe_push),
        .q_item         (fe_item)
    );

    i2cee_queue #(
        .WIDTH ($bits(item_t)),
        .DEPTH (CMD_QUEUE_DEPTH)
    ) u_cmd_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fe_push),
        .din   (fe_item),
        .full  (cq_full),
        .pop   (cq_pop),
        .dout  (be_item),
        .empty (cq_empty)
    );

    i2cee_back #(
        .MAX_BURST (MAX_BURST)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .cq_empty (cq_empty),
        .item     (be_item),
        .cq_pop   (cq_pop),
        .rq_full  (rq_full),
        .rq_push  (rq_push),
        .res      (be_res)
    );

    i2cee_queue #(
        .WIDTH ($bits(result_t)),
        .DEPTH (RES_QUEUE_DEPTH)
    ) u_res_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (rq_push),
        .din   (be_res),
        .full  (rq_full),
        .pop   (pop),
        .dout  (out_res),
        .empty (empty)
    );

    assign scl_release = out_res.scl_release;
    assign sda_release = out_res.sda_release;
    assign rdata       = out_res.rdata;
    assign rdata_valid = out_res.rdata_valid;
    assign done_res    = out_res.done_res;
    assign nack_count  = out_res.nack_count;
    assign busy_res    = out_res.busy_res;

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the serial EEPROM bus master. A cycle-accurate
// software copy of the bus sequencer predicts the line levels, read bytes,
// NACK count and status of every beat taken at the command queue. A monitor
// checks each result beat against the oldest prediction. Short writes and
// reads run under several timing and address settings and under several
// patterns of sender idling and receiver back-pressure.
// ----------------------------------------------------------------------------
module tb_top;

    import i2cee_pkg::*;

    localparam int         BURST_MAX   = 128;
    localparam int         QUIET_LIMIT = 5000;
    localparam logic [1:0] CMD_NONE    = 2'd3;

    typedef struct packed {
        logic [1:0]  cmd;
        logic        sda;
        logic        rnw;
        logic [15:0] addr;
        logic [7:0]  count;
        logic [7:0]  wdata;
    } bus_beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [1:0]  cmd = CMD_TICK;
    logic        sda_in = 1'b0;
    logic        read_not_write = 1'b0;
    logic [15:0] mem_address = 16'd0;
    logic [7:0]  byte_count = 8'd0;
    logic [7:0]  wdata = 8'd0;
    logic        empty;
    logic        pop = 1'b0;
    logic        scl_release;
    logic        sda_release;
    logic [7:0]  rdata;
    logic        rdata_valid;
    logic        done_res;
    logic [7:0]  nack_count;
    logic        busy_res;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = REG_DEVICE_ADDRESS;
    logic [15:0] cfg_data = 16'd0;

    i2c_eeprom_access_master #(
        .MAX_BURST(BURST_MAX)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .cmd(cmd),
        .sda_in(sda_in),
        .read_not_write(read_not_write),
        .mem_address(mem_address),
        .byte_count(byte_count),
        .wdata(wdata),
        .empty(empty),
        .pop(pop),
        .scl_release(scl_release),
        .sda_release(sda_release),
        .rdata(rdata),
        .rdata_valid(rdata_valid),
        .done_res(done_res),
        .nack_count(nack_count),
        .busy_res(busy_res),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    bus_beat_t cmd_beats [$];
    result_t   predicted_levels [$];
    result_t   oldest_levels;
    int        mismatches = 0;
    int        quiet_cycles = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;

    // Sequencer copy
    logic [6:0]  reg_dev = RST_DEVICE_ADDRESS;
    logic [15:0] reg_half = RST_HALF_TICKS;
    logic [15:0] reg_hold = RST_HOLD_TICKS;
    phase_t      seq_phase = P_IDLE;
    logic [15:0] seq_ticks = 16'd0;
    logic [3:0]  seq_bit = 4'd0;
    logic [7:0]  seq_shift = 8'd0;
    logic [7:0]  seq_left = 8'd0;
    logic [15:0] seq_addr = 16'd0;
    logic [7:0]  seq_nacks = 8'd0;
    logic [7:0]  seq_ptr = 8'd0;
    logic [7:0]  seq_buf [BURST_MAX];
    stage_t      seq_stage = S_DEV;
    logic        seq_read = 1'b0;

    initial begin
        forever #2 clk = ~clk;
    end

    function automatic logic scl_of(phase_t p);
        logic lvl;
        case (p)
            P_IDLE, P_STA_A, P_STA_B, P_WHI, P_AHI1, P_AHI2, P_RHI1, P_RHI2,
            P_MHI, P_NHI, P_SPB, P_SPC: lvl = 1'b1;
            default: lvl = 1'b0;
        endcase
        return lvl;
    endfunction

    function automatic logic sda_of(phase_t p);
        logic lvl;
        case (p)
            P_WLO, P_WHI: lvl = seq_shift[7];
            P_STA_B, P_STA_C, P_MLO, P_MHI, P_SPA, P_SPB: lvl = 1'b0;
            default: lvl = 1'b1;
        endcase
        return lvl;
    endfunction

    function automatic void enter_phase(phase_t p);
        logic [15:0] d;
        case (p)
            P_STA_A, P_STA_B, P_AHI1, P_AHI2, P_RHI1, P_RHI2, P_SPB, P_SPC:
                d = reg_hold;
            default: d = reg_half;
        endcase
        seq_phase = p;
        seq_ticks = (d == 16'd0) ? 16'd1 : d;
    endfunction

    function automatic void send_byte(logic [7:0] b);
        seq_shift = b;
        seq_bit = 4'd0;
        enter_phase(P_WLO);
    endfunction

    function automatic void send_data();
        logic [7:0] b;
        b = (seq_ptr < BURST_MAX) ? seq_buf[seq_ptr[6:0]] : 8'd0;
        seq_ptr = seq_ptr + 8'd1;
        send_byte(b);
    endfunction

    function automatic void after_ack();
        case (seq_stage)
            S_DEV:
            begin
                seq_stage = S_AHI;
                send_byte(seq_addr[15:8]);
            end
            S_AHI:
            begin
                seq_stage = S_ALO;
                send_byte(seq_addr[7:0]);
            end
            S_ALO:
            begin
                if (seq_read)
                begin
                    seq_stage = S_DEVR;
                    enter_phase(P_STA_A);
                end
                else
                begin
                    seq_stage = S_DATA;
                    send_data();
                end
            end
            S_DATA:
            begin
                seq_left = seq_left - 8'd1;
                if (seq_left != 8'd0)
                    send_data();
                else
                    enter_phase(P_SPA);
            end
            default:
            begin
                seq_stage = S_READ;
                seq_shift = 8'd0;
                seq_bit = 4'd0;
                enter_phase(P_RLO);
            end
        endcase
    endfunction

    function automatic result_t step_sequencer(bus_beat_t b);
        result_t    r;
        phase_t     p;
        logic [7:0] n;
        r = '0;
        r.scl_release = scl_of(seq_phase);
        r.sda_release = sda_of(seq_phase);
        r.busy_res = (seq_phase != P_IDLE);
        if (b.cmd == CMD_TICK && seq_phase != P_IDLE)
        begin
            p = seq_phase;
            if (p == P_AHI1 && seq_ticks == 16'd1 && b.sda && seq_nacks != 8'd255)
                seq_nacks = seq_nacks + 8'd1;
            if (p == P_RHI1 && seq_ticks == 16'd1)
            begin
                seq_shift = {seq_shift[6:0], b.sda};
                seq_bit = seq_bit + 4'd1;
                if (seq_bit == 4'd8)
                begin
                    r.rdata = seq_shift;
                    r.rdata_valid = 1'b1;
                end
            end
            seq_ticks = seq_ticks - 16'd1;
            if (seq_ticks == 16'd0)
            begin
                case (p)
                    P_STA_A: enter_phase(P_STA_B);
                    P_STA_B: enter_phase(P_STA_C);
                    P_STA_C: send_byte({reg_dev, seq_stage == S_DEVR});
                    P_WLO:   enter_phase(P_WHI);
                    P_WHI:
                    begin
                        seq_shift = {seq_shift[6:0], 1'b0};
                        seq_bit = seq_bit + 4'd1;
                        enter_phase((seq_bit < 4'd8) ? P_WLO : P_ALO);
                    end
                    P_ALO:   enter_phase(P_AHI1);
                    P_AHI1:  enter_phase(P_AHI2);
                    P_AHI2:  enter_phase(P_AEND);
                    P_AEND:  after_ack();
                    P_RLO:   enter_phase(P_RHI1);
                    P_RHI1:  enter_phase(P_RHI2);
                    P_RHI2:
                    begin
                        if (seq_bit < 4'd8)
                            enter_phase(P_RLO);
                        else
                        begin
                            seq_left = seq_left - 8'd1;
                            enter_phase((seq_left != 8'd0) ? P_MLO : P_NLO);
                        end
                    end
                    P_MLO:   enter_phase(P_MHI);
                    P_MHI:
                    begin
                        seq_shift = 8'd0;
                        seq_bit = 4'd0;
                        enter_phase(P_RLO);
                    end
                    P_NLO:   enter_phase(P_NHI);
                    P_NHI:   enter_phase(P_SPA);
                    P_SPA:   enter_phase(P_SPB);
                    P_SPB:   enter_phase(P_SPC);
                    default:
                    begin
                        r.done_res = 1'b1;
                        seq_phase = P_IDLE;
                        seq_ticks = 16'd0;
                        seq_ptr = 8'd0;
                    end
                endcase
            end
        end
        else if (b.cmd == CMD_LOAD || b.cmd == CMD_START)
        begin
            if (b.cmd == CMD_LOAD && seq_phase == P_IDLE && seq_ptr < BURST_MAX)
            begin
                seq_buf[seq_ptr[6:0]] = b.wdata;
                seq_ptr = seq_ptr + 8'd1;
            end
            if (b.cmd == CMD_START && seq_phase == P_IDLE)
            begin
                n = b.count;
                if (n == 8'd0)
                    n = 8'd1;
                if (n > BURST_MAX)
                    n = 8'(BURST_MAX);
                seq_left = n;
                seq_addr = b.addr;
                seq_read = b.rnw;
                seq_nacks = 8'd0;
                seq_ptr = 8'd0;
                seq_stage = S_DEV;
                seq_bit = 4'd0;
                seq_shift = 8'd0;
                enter_phase(P_STA_A);
            end
            r.scl_release = scl_of(seq_phase);
            r.sda_release = sda_of(seq_phase);
            r.busy_res = (seq_phase != P_IDLE);
        end
        r.nack_count = seq_nacks;
        return r;
    endfunction

    function automatic void check_field(string what, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d, actual %0d", $time, what, want, got);
            mismatches++;
        end
    endfunction

    // Driver: hold the beat while full, otherwise present the next one or idle
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
                predicted_levels.push_back(step_sequencer(cmd_beats.pop_front()));
            if (!(push && full))
            begin
                if (cmd_beats.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    push <= 1'b1;
                    cmd <= cmd_beats[0].cmd;
                    sda_in <= cmd_beats[0].sda;
                    read_not_write <= cmd_beats[0].rnw;
                    mem_address <= cmd_beats[0].addr;
                    byte_count <= cmd_beats[0].count;
                    wdata <= cmd_beats[0].wdata;
                end
                else
                    push <= 1'b0;
            end
        end
    end

    // Monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (predicted_levels.size() == 0)
                begin
                    $display("%0t: result beat with none predicted", $time);
                    mismatches++;
                end
                else
                begin
                    oldest_levels = predicted_levels.pop_front();
                    check_field("scl_release", oldest_levels.scl_release, scl_release);
                    check_field("sda_release", oldest_levels.sda_release, sda_release);
                    check_field("rdata", oldest_levels.rdata, rdata);
                    check_field("rdata_valid", oldest_levels.rdata_valid, rdata_valid);
                    check_field("done_res", oldest_levels.done_res, done_res);
                    check_field("nack_count", oldest_levels.nack_count, nack_count);
                    check_field("busy_res", oldest_levels.busy_res, busy_res);
                end
            end
            pop <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("FAILED: results differ");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic add_beat(logic [1:0] c, logic r, logic [15:0] a, logic [7:0] n,
                            logic [7:0] w);
        bus_beat_t b;
        b.cmd = c;
        b.sda = 1'($urandom_range(0, 1));
        b.rnw = r;
        b.addr = a;
        b.count = n;
        b.wdata = w;
        cmd_beats.push_back(b);
    endtask

    task automatic add_tick();
        add_beat(CMD_TICK, 1'($urandom), 16'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic add_load(logic [7:0] w);
        add_beat(CMD_LOAD, 1'($urandom), 16'($urandom), 8'($urandom), w);
    endtask

    task automatic add_noise();
        case ($urandom_range(0, 2))
            0: add_load(8'($urandom));
            1: add_beat(CMD_START, 1'($urandom), 16'($urandom), 8'($urandom),
                        8'($urandom));
            default: add_beat(CMD_NONE, 1'($urandom), 16'($urandom), 8'($urandom),
                              8'($urandom));
        endcase
    endtask

    function automatic int clamp_count(logic [7:0] count);
        if (count == 8'd0)
            return 1;
        if (count > BURST_MAX)
            return BURST_MAX;
        return count;
    endfunction

    function automatic int xfer_ticks(logic rnw, logic [7:0] count);
        int h;
        int l;
        int n;
        int frame;
        int edge_t;
        h = (reg_half == 16'd0) ? 1 : reg_half;
        l = (reg_hold == 16'd0) ? 1 : reg_hold;
        n = clamp_count(count);
        frame = 18 * h + 2 * l;
        edge_t = 2 * l + h;
        if (rnw)
            return 3 * edge_t + 4 * frame + n * (8 * (h + 2 * l) + 2 * h);
        return 2 * edge_t + (3 + n) * frame;
    endfunction

    // Ticks while the bus is busy, with ignored beats mixed in
    task automatic busy_ticks(int dur, int noise_permille);
        int i;
        for (i = 0; i < dur; i++)
        begin
            if ($urandom_range(0, 999) < noise_permille)
                add_noise();
            add_tick();
        end
    endtask

    // Start, then exactly enough ticks to reach STOP, with busy-time noise
    task automatic transfer(logic rnw, logic [15:0] addr, logic [7:0] count,
                            int noise_permille);
        int dur;
        dur = xfer_ticks(rnw, count);
        add_beat(CMD_START, rnw, addr, count, 8'($urandom));
        busy_ticks(dur, noise_permille);
        repeat ($urandom_range(0, 2)) add_tick();
    endtask

    task automatic wait_drained();
        while (cmd_beats.size() != 0 || push || predicted_levels.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            REG_DEVICE_ADDRESS: reg_dev = data[6:0];
            REG_HALF_TICKS:     reg_half = data;
            default:            reg_hold = data;
        endcase
    endtask

    task automatic program_bus(logic [6:0] dev, logic [15:0] half, logic [15:0] hold);
        logic [15:0] junk;
        junk = 16'($urandom);
        write_reg(REG_DEVICE_ADDRESS, {junk[15:7], dev});
        write_reg(REG_HALF_TICKS, half);
        write_reg(REG_HOLD_TICKS, hold);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial begin : stimulus
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Reset timing and address: idle ticks, unknown code, loads, write opening
        send_idle_pct = 0;
        recv_stall_pct = 0;
        add_tick();
        add_tick();
        add_beat(CMD_NONE, 1'($urandom), 16'($urandom), 8'($urandom), 8'($urandom));
        add_load(8'h00);
        add_load(8'hFF);
        add_load(8'hA5);
        add_beat(CMD_START, 1'b0, 16'hFFFF, 8'd2, 8'($urandom));
        repeat (40) add_tick();
        wait_drained();

        // Zero phase lengths mid-write: finish it, then idle ticks
        program_bus(7'd127, 16'd0, 16'd0);
        busy_ticks(100, 20);
        repeat (10) add_tick();
        wait_drained();

        // Read of zero length under sender idling
        send_idle_pct = 76;
        recv_stall_pct = 0;
        transfer(1'b1, 16'h0000, 8'd0, 20);
        wait_drained();

        // Unequal short and long phases under receiver stalls
        send_idle_pct = 0;
        recv_stall_pct = 76;
        program_bus(7'd37, 16'd1, 16'd2);
        add_load(8'($urandom));
        transfer(1'b0, 16'($urandom), 8'd1, 20);
        wait_drained();

        // Longest phases and an oversized read count, both sides idling
        send_idle_pct = 15;
        recv_stall_pct = 15;
        program_bus(7'd85, 16'hFFFF, 16'hFFFF);
        add_load(8'($urandom));
        add_beat(CMD_START, 1'b1, 16'($urandom), 8'd200, 8'($urandom));
        repeat (30) add_tick();
        wait_drained();
        repeat (8) @(posedge clk);

        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// File: i2c_eeprom_access_master.f
src/i2cee_pkg.sv
src/i2cee_queue.sv
src/i2cee_front.sv
src/i2cee_back.sv
src/i2c_eeprom_access_master.sv
tb/tb_top.sv
